// File: design/lpfc_pkg.sv
// lpfc_pkg: shared types and fixed widths for the LRU page fault counter.
// No dependencies; imported by lpfc_cell, lru_page_fault_counter and its bench.
`timescale 1ns / 1ps
`default_nettype none
package lpfc_pkg;

   localparam int PAGE_W  = 16;  // width of the page fields on the ports
   localparam int COUNT_W = 16;  // width of the fault count
   localparam int LIMIT_W = 5;   // width of the frame limit register
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

   // Per-cycle control broadcast to every cell of the recency stack.
   typedef struct packed {
      logic advance;  // a reference transfers this cycle
      logic clear;    // end of sequence: drop all entries
      logic hit;      // the reference matched a resident page
      logic evict;    // fault with the store at or above its limit
   } ctl_type;

endpackage
`default_nettype wire

// File: design/lpfc_cell.sv
// lpfc_cell: one position of the LRU recency stack (position 0 = most recent).
// Depends on lpfc_pkg for ctl_type.
`timescale 1ns / 1ps
`default_nettype none
module lpfc_cell
   import lpfc_pkg::*;
#(
   parameter int TAG_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ctl_type             ctl,
   input  wire logic [TAG_BITS-1:0] lookup_tag,
   input  wire logic [TAG_BITS-1:0] prev_tag,
   input  wire logic                prev_valid,
   input  wire logic                next_valid,
   input  wire logic                go_in,
   output logic                     go_out,
   output logic                     match,
   output logic                     valid_out,
   output logic [TAG_BITS-1:0]      tag_out,
   output logic [TAG_BITS-1:0]      victim_tag
);

   logic                valid_ff;
   logic                valid_in;
   logic [TAG_BITS-1:0] tag_ff;
   logic [TAG_BITS-1:0] tag_in;
   logic                stop;
   logic                load;

   assign match = valid_ff && (tag_ff == lookup_tag);

   // Stop the shift here: at the hit, at the oldest entry on eviction,
   // or at the first empty position when the store grows.
   always_comb begin
      if (ctl.hit) begin
         stop = match;
      end else if (ctl.evict) begin
         stop = valid_ff && !next_valid;
      end else begin
         stop = !valid_ff;
      end
   end

   assign go_out     = go_in && !stop;
   assign load       = ctl.advance && go_in;
   assign victim_tag = (ctl.evict && go_in && stop) ? tag_ff : '0;
   assign valid_out  = valid_ff;
   assign tag_out    = tag_ff;

   always_comb begin
      valid_in = valid_ff;
      tag_in   = tag_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (load) begin
         valid_in = prev_valid;
         tag_in   = prev_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

endmodule
`default_nettype wire

// File: design/lru_page_fault_counter.sv
// lru_page_fault_counter: LRU page store built as a shifting recency stack of cells.
// Results: one result per reference, on rsp_* in the cycle after the transfer.
// Throughput: one reference per cycle; busy stays low, as the whole cell chain updates on each transfer.
// Reset: synchronous; empties the store, zeroes the fault count, limit returns to 16.
// Depends on lpfc_pkg and lpfc_cell.
`timescale 1ns / 1ps
`default_nettype none
module lru_page_fault_counter
   import lpfc_pkg::*;
#(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // reference channel
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [PAGE_W-1:0]  req_page_number,
   input  wire logic               req_last_in_run,
   // result channel, one-cycle strobe, no backpressure
   output logic                    rsp_strobe,
   output logic                    rsp_is_fault,
   output logic                    rsp_did_evict,
   output logic [PAGE_W-1:0]       rsp_evicted_page,
   output logic [COUNT_W-1:0]      rsp_fault_count,
   output logic                    rsp_run_done,
   // frame limit register
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [LIMIT_W-1:0] csr_data
);

   // Tags keep only the page bits that take part in the compare.
   localparam int TAG_BITS = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
   localparam int OCC_W    = $clog2(MAX_FRAMES + 1);
   localparam int CMP_W    = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_FRAMES);

   logic                 accept;
   ctl_type              ctl;
   logic [TAG_BITS-1:0]  lookup_tag;

   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic [OCC_W-1:0]     occ_ff, occ_in;
   logic [COUNT_W-1:0]   faults_ff, faults_in, faults_next;
   logic [CMP_W-1:0]     limit_eff;
   logic                 at_limit;

   // Per-cell wires; go[i] enables shifting into cell i.
   logic [MAX_FRAMES:0]  go;
   logic [MAX_FRAMES-1:0] match_vec;
   logic [MAX_FRAMES-1:0] valid_vec;
   logic [TAG_BITS-1:0]   tag_vec    [MAX_FRAMES];
   logic [TAG_BITS-1:0]   victim_vec [MAX_FRAMES];
   logic [TAG_BITS-1:0]   victim;

   // Registered result.
   logic                 strobe_ff;
   logic                 is_fault_ff, did_evict_ff, run_done_ff;
   logic [PAGE_W-1:0]    evicted_ff;
   logic [COUNT_W-1:0]   count_ff;

   assign busy       = 1'b0;
   assign csr_ready  = 1'b1;
   assign accept     = start && !busy;
   assign lookup_tag = req_page_number[TAG_BITS-1:0];

   // Clamp the limit: zero acts as one, anything above the store size as the size.
   always_comb begin
      if (limit_ff == '0) begin
         limit_eff = CMP_W'(1);
      end else if (CMP_W'(limit_ff) > MAX_CMP) begin
         limit_eff = MAX_CMP;
      end else begin
         limit_eff = CMP_W'(limit_ff);
      end
   end

   assign at_limit = CMP_W'(occ_ff) >= limit_eff;

   assign ctl.advance = accept;
   assign ctl.clear   = accept && req_last_in_run;
   assign ctl.hit     = |match_vec;
   assign ctl.evict   = !ctl.hit && at_limit;

   // Shift chain: the new page enters at the head, everything ahead of the
   // stop point moves one place older.
   assign go[0] = 1'b1;

   for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
      logic [TAG_BITS-1:0] prev_tag;
      logic                prev_valid;
      logic                next_valid;

      if (i == 0) begin : g_head
         assign prev_tag   = lookup_tag;
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_tag   = tag_vec[i-1];
         assign prev_valid = valid_vec[i-1];
      end

      if (i == MAX_FRAMES - 1) begin : g_tail
         assign next_valid = 1'b0;
      end else begin : g_mid
         assign next_valid = valid_vec[i+1];
      end

      lpfc_cell #(
         .TAG_BITS (TAG_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .lookup_tag (lookup_tag),
         .prev_tag   (prev_tag),
         .prev_valid (prev_valid),
         .next_valid (next_valid),
         .go_in      (go[i]),
         .go_out     (go[i+1]),
         .match      (match_vec[i]),
         .valid_out  (valid_vec[i]),
         .tag_out    (tag_vec[i]),
         .victim_tag (victim_vec[i])
      );
   end

   // Only the cell holding the oldest entry drives a nonzero victim.
   always_comb begin
      victim = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         victim = victim | victim_vec[i];
      end
   end

   // Saturating fault count including this reference.
   assign faults_next = (!ctl.hit && faults_ff != COUNT_MAX) ?
                        faults_ff + COUNT_W'(1) : faults_ff;

   always_comb begin
      limit_in  = limit_ff;
      occ_in    = occ_ff;
      faults_in = faults_ff;
      if (csr_valid && csr_ready) begin
         limit_in = csr_data;
      end
      if (ctl.clear) begin
         occ_in    = '0;
         faults_in = '0;
      end else if (accept) begin
         faults_in = faults_next;
         if (!ctl.hit && !ctl.evict) begin
            occ_in = occ_ff + OCC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= LIMIT_RESET;
         occ_ff    <= '0;
         faults_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         limit_ff  <= limit_in;
         occ_ff    <= occ_in;
         faults_ff <= faults_in;
         strobe_ff <= accept;
      end
   end

   // Hold the result fields for the strobe cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         is_fault_ff  <= !ctl.hit;
         did_evict_ff <= ctl.evict;
         evicted_ff   <= PAGE_W'(victim);
         count_ff     <= faults_next;
         run_done_ff  <= req_last_in_run;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_is_fault     = is_fault_ff;
   assign rsp_did_evict    = did_evict_ff;
   assign rsp_evicted_page = evicted_ff;
   assign rsp_fault_count  = count_ff;
   assign rsp_run_done     = run_done_ff;

   // A page is resident at most once.
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("page matched in more than one cell");

   // The number of occupied cells equals the occupancy count.
   a_occ_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(occ_ff))
      else $error("occupancy count disagrees with valid cells");

   // An eviction only ever comes with a fault.
   a_evict_is_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_did_evict |-> rsp_is_fault)
      else $error("eviction reported on a hit");

   // After the last reference of a run the store is empty.
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_in_run |=> occ_ff == '0 && faults_ff == '0)
      else $error("store not cleared after end of run");

endmodule
`default_nettype wire

// File: tb/lru_page_fault_counter_tb.sv
// lru_page_fault_counter_tb: self-checking bench for the LRU page fault counter.
// Drives page references and frame limit writes, predicts each result with an
// in-bench LRU store, and checks every strobed result. Depends on lpfc_pkg and lru_page_fault_counter.
`timescale 1ns / 1ps
module lru_page_fault_counter_tb;
   import lpfc_pkg::*;

   localparam int MAX_FRAMES  = 16;
   localparam int PAGE_BITS   = 16;
   localparam int RANDOM_REFS = 1200;
   localparam int CYCLE_LIMIT = 500000;

   // One pending reference and the cycles to idle before presenting it.
   typedef struct {
      logic [PAGE_W-1:0] page;
      logic              last;
      int unsigned       gap;
   } page_ref_type;

   // What one reference must produce on the rsp_ ports.
   typedef struct packed {
      logic               is_fault;
      logic               did_evict;
      logic [PAGE_W-1:0]  evicted_page;
      logic [COUNT_W-1:0] fault_count;
      logic               run_done;
   } fault_result_type;

   // Clock and reset; reset is held high from time zero and then released for good.
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   // Block inputs, all at known values from time zero.
   logic               start           = 1'b0;
   logic [PAGE_W-1:0]  req_page_number = '0;
   logic               req_last_in_run = 1'b0;
   logic               csr_valid       = 1'b0;
   logic [LIMIT_W-1:0] csr_data        = '0;

   logic               busy;
   logic               rsp_strobe;
   logic               rsp_is_fault;
   logic               rsp_did_evict;
   logic [PAGE_W-1:0]  rsp_evicted_page;
   logic [COUNT_W-1:0] rsp_fault_count;
   logic               rsp_run_done;
   logic               csr_ready;

   lru_page_fault_counter #(
      .MAX_FRAMES(MAX_FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_page_number (req_page_number),
      .req_last_in_run (req_last_in_run),
      .rsp_strobe      (rsp_strobe),
      .rsp_is_fault    (rsp_is_fault),
      .rsp_did_evict   (rsp_did_evict),
      .rsp_evicted_page(rsp_evicted_page),
      .rsp_fault_count (rsp_fault_count),
      .rsp_run_done    (rsp_run_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   // References waiting to be driven, and results owed by the block, oldest first.
   page_ref_type     pending_refs[$];
   fault_result_type owed_results[$];

   // Shadow copy of the page store: slot contents, recency rank per slot
   // (0 = most recent), slots in use, fault count and the limit register.
   logic [PAGE_W-1:0]  shadow_pages [MAX_FRAMES];
   logic [3:0]         shadow_rank  [MAX_FRAMES];
   logic [4:0]         shadow_occupied;
   logic [COUNT_W-1:0] shadow_faults;
   logic [LIMIT_W-1:0] shadow_limit_reg;

   int error_count    = 0;
   int cycle_count    = 0;
   int refs_sent      = 0;
   int hits_seen      = 0;
   int faults_seen    = 0;
   int evictions_seen = 0;
   int runs_seen      = 0;
   int limits_written = 0;
   int peak_count     = 0;

   // ---------------------------------------------------------------------
   // LRU store prediction
   // ---------------------------------------------------------------------

   // Drop every occupied entry and the count; slot contents are never read
   // again until rewritten, so they are left alone.
   function automatic void clear_shadow_store();
      int i;
      for (i = 0; i < MAX_FRAMES; i++) shadow_rank[i] = '0;
      shadow_occupied = '0;
      shadow_faults   = '0;
   endfunction

   // Age every occupied slot that is more recent than the given rank.
   function automatic void age_slots_below(logic [4:0] below);
      int i;
      for (i = 0; i < shadow_occupied; i++)
         if (shadow_rank[i] < below) shadow_rank[i] = shadow_rank[i] + 4'd1;
   endfunction

   // Apply one reference to the shadow store and return what the block owes.
   function automatic fault_result_type lru_lookup(logic [PAGE_W-1:0] page, logic last);
      fault_result_type r;
      logic [4:0]       frame_cap;
      int               hit_slot;
      int               victim_slot;
      int               i;
      r        = '0;
      hit_slot = -1;
      // A zero limit acts as one frame, anything past the store size as all of it.
      if (shadow_limit_reg == '0) frame_cap = 5'd1;
      else if (shadow_limit_reg > MAX_FRAMES) frame_cap = 5'(MAX_FRAMES);
      else frame_cap = shadow_limit_reg;

      for (i = 0; i < shadow_occupied; i++)
         if (hit_slot < 0 && shadow_pages[i] == page) hit_slot = i;

      if (hit_slot >= 0) begin
         age_slots_below({1'b0, shadow_rank[hit_slot]});
         shadow_rank[hit_slot] = '0;
      end else begin
         r.is_fault = 1'b1;
         if (shadow_faults != COUNT_MAX) shadow_faults = shadow_faults + 1'b1;
         if (shadow_occupied >= frame_cap) begin
            // Full, or over a limit lowered mid-sequence: reuse the oldest slot.
            victim_slot = 0;
            for (i = 0; i < shadow_occupied; i++)
               if (shadow_rank[i] + 1 == shadow_occupied) victim_slot = i;
            r.did_evict    = 1'b1;
            r.evicted_page = shadow_pages[victim_slot];
            age_slots_below({1'b0, shadow_rank[victim_slot]});
            shadow_pages[victim_slot] = page;
            shadow_rank[victim_slot]  = '0;
         end else begin
            age_slots_below(shadow_occupied);
            shadow_pages[shadow_occupied] = page;
            shadow_rank[shadow_occupied]  = '0;
            shadow_occupied = shadow_occupied + 1'b1;
         end
      end
      r.fault_count = shadow_faults;
      r.run_done    = last;
      if (last) clear_shadow_store();
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Reporting
   // ---------------------------------------------------------------------

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH @%0t: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
   endtask

   // ---------------------------------------------------------------------
   // Driver: present queued references, predict each one on its transfer
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_refs
      page_ref_type next_ref;
      if (reset) begin
         start <= 1'b0;
      end else begin
         // A transfer happened at this edge: the shadow store advances now.
         if (start && !busy) begin
            owed_results.push_back(lru_lookup(req_page_number, req_last_in_run));
            refs_sent++;
         end
         // Hold the current reference while busy; otherwise load the next one
         // or idle. start gets at most one assignment per edge.
         if (!start || !busy) begin
            if (pending_refs.size() == 0) begin
               start <= 1'b0;
            end else if (pending_refs[0].gap != 0) begin
               pending_refs[0].gap = pending_refs[0].gap - 1;
               start <= 1'b0;
            end else begin
               next_ref = pending_refs.pop_front();
               start           <= 1'b1;
               req_page_number <= next_ref.page;
               req_last_in_run <= next_ref.last;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: every strobe must match the oldest owed result
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_results
      fault_result_type want;
      if (!reset && rsp_strobe) begin
         if (owed_results.size() == 0) begin
            report_mismatch("result strobe with no reference outstanding");
         end else begin
            want = owed_results.pop_front();
            check_field("is_fault",     rsp_is_fault,     want.is_fault);
            check_field("did_evict",    rsp_did_evict,    want.did_evict);
            check_field("evicted_page", rsp_evicted_page, want.evicted_page);
            check_field("fault_count",  rsp_fault_count,  want.fault_count);
            check_field("run_done",     rsp_run_done,     want.run_done);
         end
         if (rsp_is_fault === 1'b1) faults_seen++;
         else hits_seen++;
         if (rsp_did_evict === 1'b1) evictions_seen++;
         if (rsp_run_done === 1'b1) runs_seen++;
         if (rsp_fault_count > peak_count) peak_count = rsp_fault_count;
      end
   end

   // Watchdog: abandon a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d results still owed",
                  cycle_count, owed_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Mostly back-to-back or short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic queue_ref(input logic [PAGE_W-1:0] page, input logic last,
                            input int unsigned gap);
      page_ref_type item;
      item.page = page;
      item.last = last;
      item.gap  = gap;
      pending_refs.push_back(item);
   endtask

   // Hold off until every queued reference has transferred and every owed
   // result has come back. Block is then idle (one result per reference).
   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_refs.size() != 0 || start || owed_results.size() != 0);
   endtask

   // Write the frame limit; only called while the block is idle.
   task automatic write_frame_limit(input logic [LIMIT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_limit_reg = value;
      limits_written++;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : run_test
      logic [PAGE_W-1:0]  pool [$];
      logic [LIMIT_W-1:0] limit_value;
      logic [PAGE_W-1:0]  page;
      int                 cap;
      int                 pool_size;
      int                 run_length;
      int                 random_refs;
      int                 i;
      bit                 end_run;
      bit                 quiet;

      shadow_limit_reg = LIMIT_RESET;
      clear_shadow_store();
      random_refs = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset limit (16): extreme page values, hits that reorder recency,
      // and a sequence that ends on a hit.
      queue_ref(16'h0000, 1'b0, pick_gap());
      queue_ref(16'hFFFF, 1'b0, pick_gap());
      queue_ref(16'h0000, 1'b0, pick_gap());
      queue_ref(16'h8000, 1'b0, pick_gap());
      queue_ref(16'h7FFF, 1'b0, pick_gap());
      queue_ref(16'hFFFF, 1'b1, pick_gap());
      wait_until_drained();

      // Two frames: fill, hit, then evict the least recent twice.
      write_frame_limit(5'd2);
      queue_ref(16'h00AA, 1'b0, pick_gap());
      queue_ref(16'h5500, 1'b0, pick_gap());
      queue_ref(16'h00AA, 1'b0, pick_gap());
      queue_ref(16'h1234, 1'b0, pick_gap());
      queue_ref(16'h5500, 1'b0, pick_gap());
      queue_ref(16'h1234, 1'b1, pick_gap());
      wait_until_drained();

      // A zero limit behaves as a single frame.
      write_frame_limit(5'd0);
      queue_ref(16'h0001, 1'b0, pick_gap());
      queue_ref(16'h0001, 1'b0, pick_gap());
      queue_ref(16'h0002, 1'b0, pick_gap());
      queue_ref(16'h0003, 1'b1, pick_gap());
      wait_until_drained();

      // Top code of the register clamps to the full store.
      write_frame_limit(5'd31);
      queue_ref(16'h0010, 1'b0, pick_gap());
      queue_ref(16'h0020, 1'b1, pick_gap());
      wait_until_drained();

      // Lower the limit under a partly filled store: extra pages stay, and
      // faults recycle the oldest slot.
      write_frame_limit(5'd4);
      for (i = 1; i <= 4; i++) queue_ref(16'(i), 1'b0, pick_gap());
      wait_until_drained();
      write_frame_limit(5'd2);
      queue_ref(16'h0005, 1'b0, pick_gap());
      queue_ref(16'h0002, 1'b0, pick_gap());
      queue_ref(16'h0006, 1'b0, pick_gap());
      queue_ref(16'h0007, 1'b1, pick_gap());
      wait_until_drained();

      // Random sequences: each phase picks a limit and a small page pool so
      // hits and evictions both occur; some phases stop short of the last
      // reference, so the next limit write lands mid-sequence.
      while (random_refs < RANDOM_REFS) begin
         wait_until_drained();
         case ($urandom_range(0, 9))
            0:       limit_value = 5'd0;
            1:       limit_value = 5'd1;
            2:       limit_value = 5'd16;
            3:       limit_value = 5'($urandom_range(17, 31));
            default: limit_value = 5'($urandom_range(2, 15));
         endcase
         write_frame_limit(limit_value);
         cap = (limit_value == 0) ? 1 : ((limit_value > MAX_FRAMES) ? MAX_FRAMES : limit_value);

         pool.delete();
         pool_size = $urandom_range(1, cap + 4);
         for (i = 0; i < pool_size; i++) pool.push_back(16'($urandom_range(0, 65535)));

         run_length = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 60);
         end_run = ($urandom_range(0, 3) != 0);
         quiet   = ($urandom_range(0, 3) == 0);
         for (i = 0; i < run_length; i++) begin
            // Mostly pool pages; a few strays from the whole page space.
            if ($urandom_range(0, 9) == 0) page = 16'($urandom_range(0, 65535));
            else page = pool[$urandom_range(0, pool_size - 1)];
            queue_ref(page, end_run && (i == run_length - 1), quiet ? 0 : pick_gap());
         end
         random_refs += run_length;
      end

      // Close the last sequence, drain, and give stray strobes a chance to show.
      queue_ref(16'($urandom_range(0, 65535)), 1'b1, 0);
      wait_until_drained();
      repeat (8) @(posedge clock);
      if (owed_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", owed_results.size()));

      $display("Drove %0d references over %0d completed sequences with %0d limit writes.",
               refs_sent, runs_seen, limits_written);
      $display("Saw %0d hits, %0d faults, %0d evictions; fault count peaked at %0d.",
               hits_seen, faults_seen, evictions_seen, peak_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
